// ===== src/mida_pkg.sv =====
// mida_pkg: types, constants and helper functions for the triclinic minimum image core
// used by minimum_image_distance_triclinic_core; depends on nothing else
package mida_pkg;

	localparam int COORD_W = 32;
	localparam int INNER_W = 40;
	localparam int CAND_W  = 42;
	localparam int MAG_W   = 41;
	localparam int NORM_W  = 84;
	localparam int INV_W   = 32;
	localparam int QUO_W   = 41;
	localparam int KMAX    = 1 << 30;
	localparam int ROOT_W  = 32;
	localparam int REM_W   = 36;

	// pipeline stage positions (index into the valid vector)
	localparam int ST_DIFF  = 0;
	localparam int ST_WRAP  = 1;
	localparam int ST_CAND  = 13;
	localparam int ST_MAG   = 14;
	localparam int ST_PP    = 15;
	localparam int ST_SQ    = 16;
	localparam int ST_NORM  = 17;
	localparam int ST_TREE  = 18;
	localparam int TREE_LV  = 5;
	localparam int ST_PREP  = 23;
	localparam int ST_ROOT  = 24;
	localparam int ST_OUT   = 56;
	localparam int NS       = 57;

	localparam int N_IMG = 27;

	localparam logic [1:0] IMG_NEG  = 2'd0;
	localparam logic [1:0] IMG_ZERO = 2'd1;
	localparam logic [1:0] IMG_POS  = 2'd2;

	typedef enum logic [2:0] {
		REG_BOX_AX = 3'd0,
		REG_BOX_BX = 3'd1,
		REG_BOX_BY = 3'd2,
		REG_BOX_CX = 3'd3,
		REG_BOX_CY = 3'd4,
		REG_BOX_CZ = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [NORM_W-1:0]        norm;
		logic signed [CAND_W-1:0] x;
		logic signed [CAND_W-1:0] y;
		logic signed [CAND_W-1:0] z;
	} cand_t;

	function automatic logic signed [INNER_W-1:0] sat_inner(input logic signed [64:0] v);
		if (v[64:INNER_W-1] == '0 || v[64:INNER_W-1] == '1) begin
			return v[INNER_W-1:0];
		end
		return v[64] ? {1'b1, {(INNER_W-1){1'b0}}} : {1'b0, {(INNER_W-1){1'b1}}};
	endfunction

	function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [CAND_W-1:0] v);
		if (v[CAND_W-1:COORD_W-1] == '0 || v[CAND_W-1:COORD_W-1] == '1) begin
			return v[COORD_W-1:0];
		end
		return v[CAND_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
	endfunction

	function automatic logic signed [CAND_W-1:0] img_term(input logic [1:0] sel,
			input logic signed [COORD_W-1:0] v);
		case (sel)
			IMG_NEG: return -CAND_W'(v);
			IMG_POS: return CAND_W'(v);
			default: return '0;
		endcase
	endfunction

	function automatic logic [MAG_W-1:0] cand_mag(input logic signed [CAND_W-1:0] v);
		logic signed [CAND_W-1:0] n;
		n = -v;
		return v[CAND_W-1] ? n[MAG_W-1:0] : v[MAG_W-1:0];
	endfunction

endpackage

// ===== src/minimum_image_distance_triclinic_core.sv =====
// minimum_image_distance_triclinic_core: pipelined minimum image displacement and distance
// depends on mida_pkg
//
// usage
//   input channel in_valid/in_stall carries two atom positions (signed Q16.16); a transaction
//   completes at a rising edge with in_valid high and in_stall low
//   output channel out_valid/out_stall returns disp_x/y/z and distance, one per input,
//   in input order
//   config channel cfg_valid/cfg_ready/cfg_index/cfg_data writes box_ax, box_bx, box_by,
//   box_cx, box_cy, box_cz (index 0 to 5); other indexes are ignored
// throughput and depth
//   one pair is accepted every cycle while no divider runs and no stall holds the pipeline;
//   the depth is set by three wrap steps of four stages each, the image search with its
//   five level compare tree and a 32 stage bit serial root
//   writing box_ax, box_by or box_cz with a nonzero length starts a reciprocal divider
//   that yields one quotient bit a cycle; cfg_ready and new inputs are held off while it runs
// reset
//   arst_n clears the pipeline valids and loads a unit cube with reciprocals of 1.0
// stall
//   every stage holds while the stage after it is full and stalled, bubbles close up,
//   so input is still taken while a finished result waits at the output and a stage is empty
module minimum_image_distance_triclinic_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic signed [31:0]          first_x,
	input  logic signed [31:0]          first_y,
	input  logic signed [31:0]          first_z,
	input  logic signed [31:0]          second_x,
	input  logic signed [31:0]          second_y,
	input  logic signed [31:0]          second_z,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [31:0]          disp_x,
	output logic signed [31:0]          disp_y,
	output logic signed [31:0]          disp_z,
	output logic [31:0]                 distance,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [2:0]                  cfg_index,
	input  logic [31:0]                 cfg_data
);

	localparam int NS = mida_pkg::NS;
	localparam int IW = mida_pkg::INNER_W;
	localparam int CW = mida_pkg::CAND_W;
	localparam int MW = mida_pkg::MAG_W;
	localparam int RW = mida_pkg::REM_W;

	// configuration and reciprocal divider
	logic [30:0]        box_ax_q, box_by_q, box_cz_q;
	logic signed [31:0] box_bx_q, box_cx_q, box_cy_q;
	logic [31:0]        inv_q [3];
	logic               busy_q;
	logic [5:0]         cnt_q;
	logic [30:0]        den_q, drem_q;
	logic [mida_pkg::QUO_W-1:0] quo_q, num_q;
	logic [1:0]         tgt_q;
	logic [31:0]        r2;
	logic               dge;
	logic [30:0]        dlen;
	logic               diag_wr;
	logic [1:0]         diag_sel;

	always_comb begin
		r2       = {1'b0, drem_q} << 1 | 32'(num_q[mida_pkg::QUO_W-1]);
		dge      = r2 >= {1'b0, den_q};
		dlen     = cfg_data[30:0];
		diag_wr  = 1'b0;
		diag_sel = 2'd0;
		case (mida_pkg::cfg_reg_t'(cfg_index))
			mida_pkg::REG_BOX_AX: begin
				diag_wr  = 1'b1;
				diag_sel = 2'd0;
			end
			mida_pkg::REG_BOX_BY: begin
				diag_wr  = 1'b1;
				diag_sel = 2'd1;
			end
			mida_pkg::REG_BOX_CZ: begin
				diag_wr  = 1'b1;
				diag_sel = 2'd2;
			end
			default: diag_wr = 1'b0;
		endcase
	end

	assign cfg_ready = !busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_ax_q <= 31'd65536;
			box_by_q <= 31'd65536;
			box_cz_q <= 31'd65536;
			box_bx_q <= '0;
			box_cx_q <= '0;
			box_cy_q <= '0;
			inv_q[0] <= 32'd16777216;
			inv_q[1] <= 32'd16777216;
			inv_q[2] <= 32'd16777216;
			busy_q   <= 1'b0;
			cnt_q    <= '0;
			den_q    <= '0;
			drem_q   <= '0;
			quo_q    <= '0;
			num_q    <= '0;
			tgt_q    <= '0;
		end else if (busy_q) begin
			if (cnt_q != 6'd0) begin
				drem_q <= dge ? 31'(r2 - {1'b0, den_q}) : r2[30:0];
				quo_q  <= {quo_q[mida_pkg::QUO_W-2:0], dge};
				num_q  <= num_q << 1;
				cnt_q  <= cnt_q - 6'd1;
			end else begin
				busy_q       <= 1'b0;
				inv_q[tgt_q] <= (quo_q[mida_pkg::QUO_W-1:32] != '0) ? '1 : quo_q[31:0];
			end
		end else if (cfg_valid) begin
			case (mida_pkg::cfg_reg_t'(cfg_index))
				mida_pkg::REG_BOX_AX: box_ax_q <= dlen;
				mida_pkg::REG_BOX_BX: box_bx_q <= cfg_data;
				mida_pkg::REG_BOX_BY: box_by_q <= dlen;
				mida_pkg::REG_BOX_CX: box_cx_q <= cfg_data;
				mida_pkg::REG_BOX_CY: box_cy_q <= cfg_data;
				mida_pkg::REG_BOX_CZ: box_cz_q <= dlen;
				default: busy_q <= 1'b0;
			endcase
			if (diag_wr) begin
				if (dlen == '0) begin
					inv_q[diag_sel] <= '0;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= 6'(mida_pkg::QUO_W);
					den_q  <= dlen;
					drem_q <= '0;
					quo_q  <= '0;
					num_q  <= (41'd1 << 40) + 41'(dlen >> 1);
					tgt_q  <= diag_sel;
				end
			end
		end
	end

	// stage handshake
	logic [NS-1:0] vld_q, load;

	always_comb begin
		load[NS-1] = !vld_q[NS-1] || !out_stall;
		for (int s = NS - 2; s >= 0; s--) begin
			load[s] = !vld_q[s] || load[s+1];
		end
	end

	assign in_stall  = busy_q || !load[0];
	assign out_valid = vld_q[NS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (load[0]) begin
				vld_q[0] <= in_valid && !busy_q;
			end
			for (int s = 1; s < NS; s++) begin
				if (load[s]) begin
					vld_q[s] <= vld_q[s-1];
				end
			end
		end
	end

	// box vectors: c, b, a in wrap order
	logic signed [31:0] vec [3][3];
	always_comb begin
		vec[0][0] = box_cx_q;
		vec[0][1] = box_cy_q;
		vec[0][2] = $signed({1'b0, box_cz_q});
		vec[1][0] = box_bx_q;
		vec[1][1] = $signed({1'b0, box_by_q});
		vec[1][2] = '0;
		vec[2][0] = $signed({1'b0, box_ax_q});
		vec[2][1] = '0;
		vec[2][2] = '0;
	end

	// difference
	logic signed [IW-1:0] diff_s1 [3];
	logic signed [IW-1:0] wd [4][3];

	always_ff @(posedge clk) begin
		if (load[mida_pkg::ST_DIFF]) begin
			diff_s1[0] <= IW'(second_x) - IW'(first_x);
			diff_s1[1] <= IW'(second_y) - IW'(first_y);
			diff_s1[2] <= IW'(second_z) - IW'(first_z);
		end
	end

	assign wd[0] = diff_s1;

	// wrap along c, b, a
	for (genvar w = 0; w < 3; w++) begin : g_wrap
		localparam int B = mida_pkg::ST_WRAP + 4 * w;
		localparam int C = 2 - w;
		logic [63:0]          plo_s1;
		logic [39:0]          phi_s1;
		logic                 neg_s1;
		logic signed [IW-1:0] d_s1 [3];
		logic signed [IW-1:0] d_s2 [3];
		logic signed [IW-1:0] d_s3 [3];
		logic signed [IW-1:0] d_s4 [3];
		logic signed [31:0]   k_s2;
		logic signed [63:0]   pr_s3 [3];
		logic [IW-1:0]        mag;
		logic signed [IW-1:0] nv;
		logic [72:0]          psum;
		logic [32:0]          qraw;
		logic [30:0]          qsat;
		logic signed [64:0]   dif [3];

		always_comb begin
			nv   = -wd[w][C];
			mag  = wd[w][C][IW-1] ? nv : wd[w][C];
			psum = 73'(plo_s1) + {1'b0, phi_s1, 32'd0} + (73'd1 << 39);
			qraw = psum[72:40];
			qsat = (qraw > 33'(mida_pkg::KMAX)) ? 31'(mida_pkg::KMAX) : qraw[30:0];
			for (int m = 0; m < 3; m++) begin
				dif[m] = 65'(d_s3[m]) - 65'(pr_s3[m]);
			end
		end

		always_ff @(posedge clk) begin
			if (load[B]) begin
				plo_s1 <= 64'(mag[31:0]) * 64'(inv_q[C]);
				phi_s1 <= 40'(mag[39:32]) * 40'(inv_q[C]);
				neg_s1 <= wd[w][C][IW-1];
				d_s1   <= wd[w];
			end
			if (load[B+1]) begin
				k_s2 <= neg_s1 ? -$signed({1'b0, qsat}) : $signed({1'b0, qsat});
				d_s2 <= d_s1;
			end
			if (load[B+2]) begin
				for (int m = 0; m < 3; m++) begin
					pr_s3[m] <= 64'(k_s2) * 64'(vec[w][m]);
				end
				d_s3 <= d_s2;
			end
			if (load[B+3]) begin
				for (int m = 0; m < 3; m++) begin
					d_s4[m] <= mida_pkg::sat_inner(dif[m]);
				end
			end
		end

		assign wd[w+1] = d_s4;
	end

	// image candidates: 0..26 x, 27..35 y, 36..38 z
	logic signed [CW-1:0] cv_s14 [39];
	logic signed [CW-1:0] cv_s15 [39];
	logic signed [CW-1:0] cv_s16 [39];
	logic signed [CW-1:0] cv_s17 [39];
	logic [MW-1:0]        mg_s15 [39];
	logic [39:0]          hh_s16 [39];
	logic [40:0]          hl_s16 [39];
	logic [41:0]          ll_s16 [39];
	logic [81:0]          sq_s17 [39];
	mida_pkg::cand_t      tr [mida_pkg::TREE_LV+1][mida_pkg::N_IMG];

	always_ff @(posedge clk) begin
		if (load[mida_pkg::ST_CAND]) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					for (int k = 0; k < 3; k++) begin
						cv_s14[i*9+j*3+k] <= CW'(wd[3][0])
							+ mida_pkg::img_term(2'(i), $signed({1'b0, box_ax_q}))
							+ mida_pkg::img_term(2'(j), box_bx_q)
							+ mida_pkg::img_term(2'(k), box_cx_q);
					end
				end
			end
			for (int j = 0; j < 3; j++) begin
				for (int k = 0; k < 3; k++) begin
					cv_s14[27+j*3+k] <= CW'(wd[3][1])
						+ mida_pkg::img_term(2'(j), $signed({1'b0, box_by_q}))
						+ mida_pkg::img_term(2'(k), box_cy_q);
				end
			end
			for (int k = 0; k < 3; k++) begin
				cv_s14[36+k] <= CW'(wd[3][2])
					+ mida_pkg::img_term(2'(k), $signed({1'b0, box_cz_q}));
			end
		end
		if (load[mida_pkg::ST_MAG]) begin
			for (int n = 0; n < 39; n++) begin
				mg_s15[n] <= mida_pkg::cand_mag(cv_s14[n]);
			end
			cv_s15 <= cv_s14;
		end
		if (load[mida_pkg::ST_PP]) begin
			for (int n = 0; n < 39; n++) begin
				hh_s16[n] <= 40'(mg_s15[n][40:21]) * 40'(mg_s15[n][40:21]);
				hl_s16[n] <= 41'(mg_s15[n][40:21]) * 41'(mg_s15[n][20:0]);
				ll_s16[n] <= 42'(mg_s15[n][20:0]) * 42'(mg_s15[n][20:0]);
			end
			cv_s16 <= cv_s15;
		end
		if (load[mida_pkg::ST_SQ]) begin
			for (int n = 0; n < 39; n++) begin
				sq_s17[n] <= (82'(hh_s16[n]) << 42) + (82'(hl_s16[n]) << 22) + 82'(ll_s16[n]);
			end
			cv_s17 <= cv_s16;
		end
		if (load[mida_pkg::ST_NORM]) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					for (int k = 0; k < 3; k++) begin
						tr[0][i*9+j*3+k].norm <= 84'(sq_s17[i*9+j*3+k])
							+ 84'(sq_s17[27+j*3+k]) + 84'(sq_s17[36+k]);
						tr[0][i*9+j*3+k].x <= cv_s17[i*9+j*3+k];
						tr[0][i*9+j*3+k].y <= cv_s17[27+j*3+k];
						tr[0][i*9+j*3+k].z <= cv_s17[36+k];
					end
				end
			end
		end
	end

	// minimum search, later image wins a tie
	for (genvar lv = 1; lv <= mida_pkg::TREE_LV; lv++) begin : g_tree
		localparam int PN = (mida_pkg::N_IMG + (1 << (lv - 1)) - 1) >> (lv - 1);
		localparam int NP = PN / 2;

		always_ff @(posedge clk) begin
			if (load[mida_pkg::ST_TREE+lv-1]) begin
				for (int n = 0; n < NP; n++) begin
					tr[lv][n] <= (tr[lv-1][2*n+1].norm <= tr[lv-1][2*n].norm)
						? tr[lv-1][2*n+1] : tr[lv-1][2*n];
				end
				if (PN % 2 == 1) begin
					tr[lv][NP] <= tr[lv-1][PN-1];
				end
			end
		end
	end

	// square root, one result bit a stage
	logic [RW-1:0]         rem_s [33];
	logic [31:0]           root_s [33];
	logic [63:0]           rad_s [33];
	logic                  over_s [33];
	logic signed [31:0]    dx_s [33];
	logic signed [31:0]    dy_s [33];
	logic signed [31:0]    dz_s [33];

	always_ff @(posedge clk) begin
		if (load[mida_pkg::ST_PREP]) begin
			rem_s[0]  <= '0;
			root_s[0] <= '0;
			rad_s[0]  <= tr[mida_pkg::TREE_LV][0].norm[63:0];
			over_s[0] <= tr[mida_pkg::TREE_LV][0].norm > 84'hFFFF_FFFF_0000_0000;
			dx_s[0]   <= mida_pkg::sat_coord(tr[mida_pkg::TREE_LV][0].x);
			dy_s[0]   <= mida_pkg::sat_coord(tr[mida_pkg::TREE_LV][0].y);
			dz_s[0]   <= mida_pkg::sat_coord(tr[mida_pkg::TREE_LV][0].z);
		end
	end

	for (genvar st = 0; st < 32; st++) begin : g_root
		logic [RW-1:0] remsh, trial;
		logic          ge;

		always_comb begin
			remsh = {rem_s[st][RW-3:0], rad_s[st][63:62]};
			trial = {2'b00, root_s[st], 2'b01};
			ge    = remsh >= trial;
		end

		always_ff @(posedge clk) begin
			if (load[mida_pkg::ST_ROOT+st]) begin
				rem_s[st+1]  <= ge ? remsh - trial : remsh;
				root_s[st+1] <= {root_s[st][30:0], ge};
				rad_s[st+1]  <= rad_s[st] << 2;
				over_s[st+1] <= over_s[st];
				dx_s[st+1]   <= dx_s[st];
				dy_s[st+1]   <= dy_s[st];
				dz_s[st+1]   <= dz_s[st];
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (load[mida_pkg::ST_OUT]) begin
			disp_x <= dx_s[32];
			disp_y <= dy_s[32];
			disp_z <= dz_s[32];
			if (over_s[32]) begin
				distance <= '1;
			end else if (rem_s[32] > RW'(root_s[32])) begin
				distance <= root_s[32] + 32'd1;
			end else begin
				distance <= root_s[32];
			end
		end
	end

endmodule

// ===== dv/minimum_image_distance_triclinic_core_tb.sv =====
// testbench for minimum_image_distance_triclinic_core: directed and random atom pairs over
// several triclinic boxes, checked against a local minimum image predictor
// depends on mida_pkg and minimum_image_distance_triclinic_core
`timescale 1ns / 1ps

module minimum_image_distance_triclinic_core_tb;

	localparam logic [2:0] REG_SPARE_LO = 3'd6;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;
	localparam longint ONE = 64'sd65536;
	localparam int WATCHDOG_LIMIT = 6000;

	typedef struct packed {
		logic signed [31:0] dx;
		logic signed [31:0] dy;
		logic signed [31:0] dz;
		logic [31:0]        len;
	} image_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic signed [31:0] first_x, first_y, first_z, second_x, second_y, second_z;
	logic out_valid;
	logic out_stall;
	logic signed [31:0] disp_x, disp_y, disp_z;
	logic [31:0] distance;
	logic cfg_valid;
	logic cfg_ready;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;

	minimum_image_distance_triclinic_core uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.first_x(first_x), .first_y(first_y), .first_z(first_z),
		.second_x(second_x), .second_y(second_y), .second_z(second_z),
		.out_valid(out_valid), .out_stall(out_stall),
		.disp_x(disp_x), .disp_y(disp_y), .disp_z(disp_z), .distance(distance),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// box model
	longint box_ax, box_bx, box_by, box_cx, box_cy, box_cz;
	logic [31:0] inv_a, inv_b, inv_c;

	image_t pending_images[$];
	int mismatches;
	int pairs_sent;
	int results_seen;
	int boxes_used;
	int idle_cycles;
	bit idle_on;
	int hold_cycles;
	int stall_burst;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [31:0] reciprocal(input longint len);
		logic [127:0] q;
		if (len == 0) begin
			return 32'd0;
		end
		q = ((128'd1 << 40) + (len >> 1)) / len;
		return (q > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
	endfunction

	function automatic longint clamp(input longint v, input int bits);
		longint lim;
		lim = (64'sd1 <<< (bits - 1)) - 1;
		if (v > lim) begin
			return lim;
		end
		if (v < -lim - 1) begin
			return -lim - 1;
		end
		return v;
	endfunction

	function automatic longint wrap_count(input longint v, input logic [31:0] inv);
		logic [127:0] p;
		longint q;
		p = 128'(v < 0 ? -v : v) * 128'(inv) + (128'd1 << 39);
		p = p >> 40;
		q = (p > 128'd1073741824) ? 64'sd1073741824 : longint'(p[63:0]);
		return v < 0 ? -q : q;
	endfunction

	function automatic logic [127:0] square(input longint v);
		logic [127:0] m;
		m = 128'(v < 0 ? -v : v);
		return m * m;
	endfunction

	function automatic logic [31:0] rounded_root(input logic [127:0] x);
		logic [63:0] r, c;
		r = 0;
		for (int b = 57; b >= 0; b--) begin
			c = r | (64'd1 << b);
			if (128'(c) * 128'(c) <= x) begin
				r = c;
			end
		end
		if (x > 128'(r) * 128'(r) + 128'(r)) begin
			r = r + 1;
		end
		return (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
	endfunction

	function automatic image_t nearest_image(input logic signed [31:0] ax, ay, az, bx, by, bz);
		longint d[3], c[3], best[3], k;
		logic [127:0] n, bestn;
		image_t res;
		d[0] = longint'(bx) - longint'(ax);
		d[1] = longint'(by) - longint'(ay);
		d[2] = longint'(bz) - longint'(az);
		k = wrap_count(d[2], inv_c);
		d[0] = clamp(d[0] - k * box_cx, 40);
		d[1] = clamp(d[1] - k * box_cy, 40);
		d[2] = clamp(d[2] - k * box_cz, 40);
		k = wrap_count(d[1], inv_b);
		d[0] = clamp(d[0] - k * box_bx, 40);
		d[1] = clamp(d[1] - k * box_by, 40);
		d[2] = clamp(d[2], 40);
		k = wrap_count(d[0], inv_a);
		d[0] = clamp(d[0] - k * box_ax, 40);
		bestn = 0;
		best = d;
		for (int i = -1; i <= 1; i++) begin
			for (int j = -1; j <= 1; j++) begin
				for (int m = -1; m <= 1; m++) begin
					c[0] = d[0] + i * box_ax + j * box_bx + m * box_cx;
					c[1] = d[1] + j * box_by + m * box_cy;
					c[2] = d[2] + m * box_cz;
					n = square(c[0]) + square(c[1]) + square(c[2]);
					if ((i == -1 && j == -1 && m == -1) || n <= bestn) begin
						bestn = n;
						best = c;
					end
				end
			end
		end
		res.dx = 32'(clamp(best[0], 32));
		res.dy = 32'(clamp(best[1], 32));
		res.dz = 32'(clamp(best[2], 32));
		res.len = rounded_root(bestn);
		return res;
	endfunction

	function automatic void apply_box_write(input logic [2:0] idx, input logic [31:0] val);
		case (idx)
			mida_pkg::REG_BOX_AX: begin
				box_ax = longint'(val[30:0]);
				inv_a = reciprocal(box_ax);
			end
			mida_pkg::REG_BOX_BX: box_bx = longint'(signed'(val));
			mida_pkg::REG_BOX_BY: begin
				box_by = longint'(val[30:0]);
				inv_b = reciprocal(box_by);
			end
			mida_pkg::REG_BOX_CX: box_cx = longint'(signed'(val));
			mida_pkg::REG_BOX_CY: box_cy = longint'(signed'(val));
			mida_pkg::REG_BOX_CZ: begin
				box_cz = longint'(val[30:0]);
				inv_c = reciprocal(box_cz);
			end
			default: ;
		endcase
	endfunction

	// result checker and watchdog
	always @(negedge clk) begin
		image_t exp_img;
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout: no transaction for %0d cycles", idle_cycles);
				$display("== FAIL ==");
				$finish;
			end
			if (out_valid && !out_stall) begin
				results_seen++;
				if (pending_images.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("unexpected result %h %h %h %h", disp_x, disp_y, disp_z, distance);
					end
				end else begin
					exp_img = pending_images.pop_front();
					if (exp_img.dx !== disp_x || exp_img.dy !== disp_y ||
							exp_img.dz !== disp_z || exp_img.len !== distance) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("mismatch #%0d: exp %h %h %h %h got %h %h %h %h",
								results_seen, exp_img.dx, exp_img.dy, exp_img.dz,
								exp_img.len, disp_x, disp_y, disp_z, distance);
						end
					end
				end
			end
		end
	end

	// receiver stall
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles--;
			out_stall <= 1'b1;
		end else if (stall_burst > 0) begin
			stall_burst--;
			out_stall <= 1'b1;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			stall_burst = $urandom_range(0, 6);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic send_pair(input logic signed [31:0] ax, ay, az, bx, by, bz);
		bit acc;
		if (idle_on && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_valid <= 1'b1;
		first_x <= ax;
		first_y <= ay;
		first_z <= az;
		second_x <= bx;
		second_y <= by;
		second_z <= bz;
		do begin
			@(negedge clk);
			acc = !in_stall;
			if (acc) begin
				pending_images.push_back(nearest_image(ax, ay, az, bx, by, bz));
				pairs_sent++;
			end
			@(posedge clk);
		end while (!acc);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_images.size() != 0) @(posedge clk);
		repeat (70) @(posedge clk);
	endtask

	task automatic write_box(input logic [2:0] idx, input logic [31:0] val);
		bit acc;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do begin
			@(negedge clk);
			acc = cfg_ready;
			@(posedge clk);
		end while (!acc);
		cfg_valid <= 1'b0;
		apply_box_write(idx, val);
		@(posedge clk);
	endtask

	task automatic load_box(input logic [31:0] ax, bx, by, cx, cy, cz);
		wait_drained();
		write_box(mida_pkg::REG_BOX_AX, ax);
		write_box(mida_pkg::REG_BOX_BX, bx);
		write_box(mida_pkg::REG_BOX_BY, by);
		write_box(mida_pkg::REG_BOX_CX, cx);
		write_box(mida_pkg::REG_BOX_CY, cy);
		write_box(mida_pkg::REG_BOX_CZ, cz);
		boxes_used++;
	endtask

	function automatic logic signed [31:0] near_coord(input longint span);
		return 32'($urandom_range(0, 32'(span * 6)) - span * 3);
	endfunction

	// mostly coordinates within a few box lengths, some across the full range
	task automatic send_random_pairs(input int count);
		longint span;
		span = box_ax > box_by ? box_ax : box_by;
		span = span > box_cz ? span : box_cz;
		if (span < ONE || span > 64'sd100000000) begin
			span = 64'sd100000000;
		end
		repeat (count) begin
			if ($urandom_range(0, 3) == 0) begin
				send_pair($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
			end else begin
				send_pair(near_coord(span), near_coord(span), near_coord(span),
					near_coord(span), near_coord(span), near_coord(span));
			end
		end
	endtask

	task automatic test_unit_cube_directed();
		send_pair(0, 0, 0, 0, 0, 0);
		send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_pair(0, 0, 0, 32'h8000, 32'h8000, 32'h8000);
		send_pair(0, 0, 0, -32'sh8000, -32'sh8000, -32'sh8000);
		send_pair(0, 0, 0, 32'h18000, 32'h0, -32'sh18000);
		send_pair(0, 0, 0, 32'h7FFF, 32'h8001, 32'h10000);
		send_pair(32'h1234_5678, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h1234_5678, 32'h1);
		send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0);
		send_pair(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
			32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
	endtask

	task automatic test_box_extremes();
		// tiny lengths saturate the reciprocal
		load_box(32'h1, 32'h0, 32'h1, 32'h0, 32'h0, 32'h1);
		send_pair(0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678);
		send_pair(32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h3);
		send_random_pairs(60);
		// zero lengths turn off the wrap along those vectors
		load_box(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h0);
		send_pair(0, 0, 0, 32'h10000, 32'h20000, 32'h7FFF_FFFF);
		send_pair(32'h7FFF_FFFF, 0, 32'h8000_0000, 32'h8000_0000, 0, 32'h7FFF_FFFF);
		send_random_pairs(60);
		// largest lengths and skew
		load_box(32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'hFFFF_FFFF);
		send_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_random_pairs(60);
		// spare indexes must leave the box alone
		wait_drained();
		write_box(REG_SPARE_LO, $urandom);
		write_box(REG_SPARE_HI, $urandom);
		send_random_pairs(40);
	endtask

	task automatic test_random_boxes(input int n_boxes, input int per_box);
		longint a, b, c;
		repeat (n_boxes) begin
			if ($urandom_range(0, 4) == 0) begin
				load_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
			end else begin
				a = $urandom_range(32'h8000, 32'h14_0000);
				b = $urandom_range(32'h8000, 32'h14_0000);
				c = $urandom_range(32'h8000, 32'h14_0000);
				load_box(32'(a) | ($urandom_range(0, 1) << 31),
					32'($urandom_range(0, 32'(a)) - a / 2),
					32'(b) | ($urandom_range(0, 1) << 31),
					32'($urandom_range(0, 32'(a)) - a / 2),
					32'($urandom_range(0, 32'(b)) - b / 2),
					32'(c) | ($urandom_range(0, 1) << 31));
			end
			send_random_pairs(per_box);
		end
	endtask

	task automatic test_backpressure();
		hold_cycles = 300;
		send_random_pairs(120);
		wait_drained();
		send_random_pairs(60);
		wait_drained();
	endtask

	task automatic test_full_rate();
		idle_on = 0;
		load_box(32'h3_0000, 32'hFFFF_8000, 32'h2_8000, 32'h1_0000, 32'hFFFF_4000, 32'h4_0000);
		send_random_pairs(250);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		first_x = '0;
		first_y = '0;
		first_z = '0;
		second_x = '0;
		second_y = '0;
		second_z = '0;
		mismatches = 0;
		pairs_sent = 0;
		results_seen = 0;
		boxes_used = 1;
		idle_cycles = 0;
		hold_cycles = 0;
		stall_burst = 0;
		idle_on = 1;
		apply_box_write(mida_pkg::REG_BOX_AX, 32'h1_0000);
		apply_box_write(mida_pkg::REG_BOX_BX, 32'h0);
		apply_box_write(mida_pkg::REG_BOX_BY, 32'h1_0000);
		apply_box_write(mida_pkg::REG_BOX_CX, 32'h0);
		apply_box_write(mida_pkg::REG_BOX_CY, 32'h0);
		apply_box_write(mida_pkg::REG_BOX_CZ, 32'h1_0000);
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_unit_cube_directed();
		send_random_pairs(100);
		test_box_extremes();
		test_random_boxes(12, 90);
		test_backpressure();
		test_full_rate();

		wait_drained();
		$display("%0d atom pairs over %0d boxes, %0d results checked, %0d mismatches",
			pairs_sent, boxes_used, results_seen, mismatches);
		$display("covered tiny, zero and maximal box lengths, skewed boxes and backpressure");
		if (mismatches == 0 && pending_images.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
